FILE: rtl/core/fir8_pkg.sv
// Shared types and constants for the eight-tap Q15 FIR filter.
`timescale 1ns / 1ps

package fir8_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int NUM_REGS   = 8;
  localparam int FRAC_SHIFT = 15;
  localparam logic [PROD_W-1:0] ROUND_BIAS = 32'h0000_4000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;

endpackage

FILE: rtl/core/fir8_tap_line.sv
// Sample history shift line and registered tap window.
`timescale 1ns / 1ps

module fir8_tap_line
  import fir8_pkg::*;
#(
  parameter int TAPS = 8
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  sample_t in_sample,
  input  logic    win_ready,
  output logic    win_valid,
  output sample_t win_data [TAPS]
);

  sample_t hist_r [TAPS-1];
  sample_t win_r  [TAPS];
  logic    win_valid_r;
  logic    accept;

  assign in_ready  = !win_valid_r || win_ready;
  assign accept    = in_valid && in_ready;
  assign win_valid = win_valid_r;
  assign win_data  = win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_valid_r <= 1'b0;
      for (int k = 0; k < TAPS - 1; k++) begin
        hist_r[k] <= '0;
      end
    end else begin
      if (in_ready) begin
        win_valid_r <= in_valid;
      end
      if (accept) begin
        hist_r[0] <= in_sample;
        for (int k = 1; k < TAPS - 1; k++) begin
          hist_r[k] <= hist_r[k-1];
        end
      end
    end
  end

  // Window: current sample, then history oldest last.
  always_ff @(posedge clk) begin
    if (accept) begin
      win_r[0] <= in_sample;
      for (int k = 1; k < TAPS; k++) begin
        win_r[k] <= hist_r[k-1];
      end
    end
  end

endmodule

FILE: rtl/core/fir8_mult.sv
// Parallel tap multipliers with registered products.
`timescale 1ns / 1ps

module fir8_mult
  import fir8_pkg::*;
#(
  parameter int TAPS = 8
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    up_valid,
  output logic    up_ready,
  input  sample_t win_data [TAPS],
  input  coef_t   coef     [TAPS],
  input  logic    dn_ready,
  output logic    dn_valid,
  output prod_t   prod     [TAPS]
);

  prod_t prod_r [TAPS];
  logic  prod_valid_r;

  assign up_ready = !prod_valid_r || dn_ready;
  assign dn_valid = prod_valid_r;
  assign prod     = prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
    end else if (up_ready) begin
      prod_valid_r <= up_valid;
    end
  end

  // 16x16 signed products are exact in 32 bits.
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      for (int k = 0; k < TAPS; k++) begin
        prod_r[k] <= PROD_W'(win_data[k] * coef[k]);
      end
    end
  end

endmodule

FILE: rtl/core/fir8_sum.sv
// Two-level registered adder tree, rounding and output register.
`timescale 1ns / 1ps

module fir8_sum
  import fir8_pkg::*;
#(
  parameter int TAPS = 8
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    up_valid,
  output logic    up_ready,
  input  prod_t   prod [TAPS],
  input  logic    out_ready,
  output logic    out_valid,
  output sample_t out_sample
);

  localparam int GRP    = 4;
  localparam int GROUPS = (TAPS + GRP - 1) / GRP;

  prod_t   pad      [GROUPS*GRP];
  prod_t   part_nxt [GROUPS];
  prod_t   part_r   [GROUPS];
  logic    part_valid_r;
  logic    part_ready;
  logic    out_valid_r;
  sample_t out_sample_r;
  prod_t   total;

  assign part_ready = !out_valid_r || out_ready;
  assign up_ready   = !part_valid_r || part_ready;
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  always_comb begin
    for (int i = 0; i < GROUPS * GRP; i++) begin
      pad[i] = '0;
    end
    for (int i = 0; i < TAPS; i++) begin
      pad[i] = prod[i];
    end
    for (int g = 0; g < GROUPS; g++) begin
      part_nxt[g] = pad[g*GRP] + pad[g*GRP+1] + pad[g*GRP+2] + pad[g*GRP+3];
    end
  end

  // Sum wraps at 32 bits; only bits 30..15 survive anyway.
  always_comb begin
    total = ROUND_BIAS;
    for (int g = 0; g < GROUPS; g++) begin
      total = total + part_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (up_ready) begin
        part_valid_r <= up_valid;
      end
      if (part_ready) begin
        out_valid_r <= part_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      part_r <= part_nxt;
    end
    if (part_ready && part_valid_r) begin
      out_sample_r <= total[FRAC_SHIFT+SAMPLE_W-1:FRAC_SHIFT];
    end
  end

endmodule

FILE: rtl/core/fir8_audio_filter.sv
// Top level of the Q15 FIR audio filter: coefficient registers and pipeline.
//
//  channel | dir | ports                                   | word
//  --------+-----+-----------------------------------------+---------------------
//  in      | in  | in_valid, in_ready, in_sample_in        | one audio sample
//  out     | out | out_valid, out_ready, out_sample_out    | one filtered sample
//  cfg     | in  | cfg_valid, cfg_ready, cfg_index, cfg_data | one coefficient
//
// One word in and one word out per cycle, sustained while out_ready stays high.
// Registered in order: window, product, partial-sum and result registers.
// Reset (synchronous, rst_n low) clears history, coefficients and all valids.
// Each stage moves when the one after it is empty or draining, so bubbles are
// squeezed out; input flows while a result waits at out until the pipe fills.
// cfg_ready is always high; writes to indexes past the tap list are dropped.
`timescale 1ns / 1ps

module fir8_audio_filter
  import fir8_pkg::*;
#(
  parameter int TAPS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sample_t              in_sample_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sample_t              out_sample_out,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  coef_t                cfg_data
);

  localparam int IDX_W = $clog2(TAPS);

  coef_t   coef_r [TAPS];
  logic    cfg_hit;
  sample_t win_data [TAPS];
  prod_t   prod     [TAPS];
  logic    win_valid;
  logic    win_ready;
  logic    prod_valid;
  logic    prod_ready;

  // Coefficient registers; only the first NUM_REGS taps are addressable.
  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid
                  && (32'(cfg_index) < 32'(NUM_REGS))
                  && (32'(cfg_index) < 32'(TAPS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TAPS; k++) begin
        coef_r[k] <= '0;
      end
    end else if (cfg_hit) begin
      coef_r[cfg_index[IDX_W-1:0]] <= cfg_data;
    end
  end

  fir8_tap_line #(.TAPS(TAPS)) u_tap_line (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample_in),
    .win_ready (win_ready),
    .win_valid (win_valid),
    .win_data  (win_data)
  );

  fir8_mult #(.TAPS(TAPS)) u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (win_valid),
    .up_ready (win_ready),
    .win_data (win_data),
    .coef     (coef_r),
    .dn_ready (prod_ready),
    .dn_valid (prod_valid),
    .prod     (prod)
  );

  fir8_sum #(.TAPS(TAPS)) u_sum (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (prod_valid),
    .up_ready   (prod_ready),
    .prod       (prod),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_sample (out_sample_out)
  );

endmodule

FILE: sim/fir8_audio_filter_tb.sv
// Self-checking bench for the eight-tap Q15 FIR audio filter: directed rows, then random phases.
`timescale 1ns / 1ps

module fir8_audio_filter_tb;
  import fir8_pkg::*;

  localparam int TAPS         = 8;
  localparam int CLK_HALF     = 6;      // 12 ns period
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 8;      // pipeline is four deep
  localparam int LONG_HOLD    = 300;    // receiver hold-off, long enough to fill the pipe
  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 175;
  localparam int CYCLE_LIMIT  = 200000;

  // Register map: tap k sits at REG_TAP_COEF_0 + k, anything from
  // REG_FIRST_UNUSED up is dropped by the block.
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COEF_0   = '0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = CFG_IDX_W'(NUM_REGS);
  localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX   = '1;

  localparam sample_t S_MAX = 16'sh7FFF;
  localparam sample_t S_MIN = 16'sh8000;
  localparam coef_t   C_MAX = 16'sh7FFF;
  localparam coef_t   C_MIN = 16'sh8000;

  typedef enum logic { ROW_COEF, ROW_SAMPLE } row_kind_t;

  // One directed row: a coefficient write or a sample, with an optional
  // hand-typed expected output.
  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [SAMPLE_W-1:0]    value;
    bit                     typed;
    sample_t                want;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  sample_t              in_sample_in;
  logic                 out_valid;
  logic                 out_ready;
  sample_t              out_sample_out;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  coef_t                cfg_data;

  // Shadow of the filter: coefficients as written, and the last TAPS-1
  // accepted samples (entry 0 is one step back).
  coef_t   coef_shadow  [TAPS]   = '{default: '0};
  sample_t past_samples [TAPS-1] = '{default: '0};

  sample_t  filtered_due [$];   // filtered words still owed by the block
  dir_row_t dir_table    [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  int cycles         = 0;
  int fails          = 0;
  int items_sent     = 0;
  int words_checked  = 0;
  int coef_sets      = 0;

  fir8_audio_filter #(
    .TAPS(TAPS)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Next filtered sample for input s; also shifts s into the history.
  // Products and sum are kept at 48 bits, then bits 30..15 of the rounded
  // sum are taken, which is the same as 32-bit wraparound.
  function automatic sample_t fir_filtered(input sample_t s);
    logic signed [47:0] acc;
    logic signed [47:0] term;
    term = s * coef_shadow[0];
    acc  = term;
    for (int k = 1; k < TAPS; k++) begin
      term = past_samples[k-1] * coef_shadow[k];
      acc  = acc + term;
    end
    acc = acc + 48'sh4000;
    for (int k = TAPS - 2; k > 0; k--) past_samples[k] = past_samples[k-1];
    past_samples[0] = s;
    return acc[FRAC_SHIFT +: SAMPLE_W];
  endfunction

  function automatic dir_row_t coef_row(input logic [CFG_IDX_W-1:0] idx, input coef_t v);
    dir_row_t r;
    r = '{ROW_COEF, idx, v, 1'b0, '0};
    return r;
  endfunction

  function automatic dir_row_t sample_row(input sample_t s);
    dir_row_t r;
    r = '{ROW_SAMPLE, '0, s, 1'b0, '0};
    return r;
  endfunction

  function automatic dir_row_t typed_row(input sample_t s, input sample_t want);
    dir_row_t r;
    r = '{ROW_SAMPLE, '0, s, 1'b1, want};
    return r;
  endfunction

  // Offer one sample; called and returns at a falling edge. The history
  // advances on acceptance, so prediction happens right there.
  task automatic send_sample(input sample_t s, input bit typed, input sample_t want);
    sample_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    do @(posedge clk); while (!in_ready);
    pred = fir_filtered(s);
    filtered_due.push_back(typed ? want : pred);
    items_sent++;
    @(negedge clk);
  endtask

  // One coefficient word; cfg_valid stays up so back-to-back writes
  // don't toggle it within a step. Caller drops it after the batch.
  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input coef_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx < REG_FIRST_UNUSED && idx < TAPS) coef_shadow[idx] = value;
    @(negedge clk);
  endtask

  // Stop offering, wait for every owed word, then let the pipe go quiet.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (filtered_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d words still owed", cycles, filtered_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request that it
  // counts down itself while the sender keeps pushing.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Scoreboard: every accepted output word against the oldest expectation.
  always @(posedge clk) begin
    sample_t want;
    if (rst_n && out_valid && out_ready) begin
      if (filtered_due.size() == 0) begin
        $error("sample_out: word %0d arrived with nothing expected", out_sample_out);
        fails++;
      end else begin
        want = filtered_due.pop_front();
        words_checked++;
        if (out_sample_out !== want) begin
          $error("sample_out mismatch: expected %0d, got %0d", want, out_sample_out);
          fails++;
        end
      end
    end
  end

  initial begin
    bit      cfg_busy;
    sample_t s;
    coef_t   c;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample_in = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    cfg_busy     = 1'b0;

    // Coefficients come out of reset at zero, so anything filters to zero.
    dir_table.push_back(typed_row(S_MAX, 16'sh0000));
    dir_table.push_back(typed_row(S_MIN, 16'sh0000));
    dir_table.push_back(typed_row(16'sh0001, 16'sh0000));
    // Tap 0 at -1.0; writes past the tap list must leave the others at zero.
    dir_table.push_back(coef_row(REG_TAP_COEF_0, C_MIN));
    dir_table.push_back(coef_row(REG_FIRST_UNUSED, 16'sh1234));
    dir_table.push_back(coef_row(REG_LAST_INDEX, C_MAX));
    // (-1.0)*(-1.0) rounds to +1.0, which wraps to full-scale negative
    dir_table.push_back(typed_row(S_MIN, 16'sh8000));
    dir_table.push_back(sample_row(S_MAX));
    dir_table.push_back(sample_row(16'sh0001));
    // All taps at max and a full-scale history: sum well beyond 32 bits
    for (int k = 0; k < TAPS; k++) begin
      dir_table.push_back(coef_row(CFG_IDX_W'(REG_TAP_COEF_0 + k), C_MAX));
    end
    for (int k = 0; k < TAPS; k++) dir_table.push_back(sample_row(S_MAX));
    // All taps at min against negative full scale, then alternating bits
    for (int k = 0; k < TAPS; k++) begin
      dir_table.push_back(coef_row(CFG_IDX_W'(REG_TAP_COEF_0 + k), C_MIN));
    end
    for (int k = 0; k < 4; k++) dir_table.push_back(sample_row(S_MIN));
    dir_table.push_back(sample_row(16'sh5555));
    dir_table.push_back(sample_row(16'shAAAA));
    dir_table.push_back(sample_row(16'sh0000));

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows; coefficient rows only go in once the pipe is empty.
    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_COEF) begin
        if (!cfg_busy) wait_drained();
        cfg_busy = 1'b1;
        write_coef(dir_table[i].idx, coef_t'(dir_table[i].value));
      end else begin
        if (cfg_busy) begin
          cfg_valid <= 1'b0;
          coef_sets++;
        end
        cfg_busy = 1'b0;
        send_sample(sample_t'(dir_table[i].value), dir_table[i].typed, dir_table[i].want);
      end
    end

    // Random phases: fresh coefficients each time, idle pattern cycles
    // through none / sender gaps / receiver stalls / both.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      for (int k = 0; k < TAPS; k++) begin
        case (ph)
          1:       c = coef_t'(int'($urandom_range(8192)) - 4096);   // gentle taps
          2:       c = C_MAX;
          3:       c = C_MIN;
          4:       c = $urandom_range(1) ? coef_t'(0) : coef_t'($urandom);
          default: c = coef_t'($urandom);
        endcase
        write_coef(CFG_IDX_W'(REG_TAP_COEF_0 + k), c);
      end
      // a stray write past the map, should be dropped
      write_coef(CFG_IDX_W'($urandom_range(32'(REG_LAST_INDEX), 32'(REG_FIRST_UNUSED))),
                 coef_t'($urandom));
      cfg_valid <= 1'b0;
      coef_sets++;

      // back-pressure: receiver holds off while the sender keeps going
      if (ph == 0) hold_req = 1'b1;

      for (int n = 0; n < PHASE_WORDS; n++) begin
        // sender pause until everything owed has come back
        if (ph == 5 && n == PHASE_WORDS / 2) wait_drained();
        case ($urandom_range(9))
          0: begin
            case ($urandom_range(3))
              0:       s = S_MAX;
              1:       s = S_MIN;
              2:       s = 16'sh0000;
              default: s = 16'shFFFF;
            endcase
          end
          1:       s = sample_t'(int'($urandom_range(512)) - 256);
          default: s = sample_t'($urandom);
        endcase
        send_sample(s, 1'b0, '0);
      end
    end

    wait_drained();

    $display("Filtered %0d samples under %0d coefficient sets, %0d words checked, %0d errors.",
             items_sent, coef_sets, words_checked, fails);
    $display("Run covered reset state, full-scale wrap, dropped writes, stalls and gaps.");
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/fir8_pkg.sv
rtl/core/fir8_tap_line.sv
rtl/core/fir8_mult.sv
rtl/core/fir8_sum.sv
rtl/core/fir8_audio_filter.sv
sim/fir8_audio_filter_tb.sv
